>>> hw/rtl/swfls_pkg.sv
package swfls_pkg;

    localparam int ADDRESS_BITS = 3;
    localparam int DATA_BITS    = 8;
    localparam int TIMER_BITS   = 13;

    localparam int FRAME_LEN    = ADDRESS_BITS + DATA_BITS;
    localparam int SEG_COUNT    = 5 + 2 * FRAME_LEN;
    localparam int SEG_BITS     = $clog2(SEG_COUNT + 1);
    localparam int FB_IDX_BITS  = $clog2(FRAME_LEN);

    localparam int TICK_W       = 12;
    localparam int DEV_W        = 3;
    localparam int BRIGHT_W     = 8;
    localparam int STORED_W     = 7;
    localparam int LEVEL_W      = 6;
    localparam int CFG_IDX_W    = 3;

    localparam logic [TICK_W-1:0] RST_SHORT    = TICK_W'(20);
    localparam logic [TICK_W-1:0] RST_LONG     = TICK_W'(70);
    localparam logic [TICK_W-1:0] RST_GAP      = TICK_W'(50);
    localparam logic [TICK_W-1:0] RST_END_HIGH = TICK_W'(180);

    localparam logic [1:0] FM_OFF  = 2'd0;
    localparam logic [1:0] FM_HIGH = 2'd2;
    localparam logic [1:0] FM_LOW  = 2'd3;

    // Segments with a fixed role; the rest are the address/data bit halves
    localparam logic [SEG_BITS-1:0] SEG_START_LO = SEG_BITS'(0);
    localparam logic [SEG_BITS-1:0] SEG_START_HI = SEG_BITS'(1);
    localparam logic [SEG_BITS-1:0] SEG_GAP      = SEG_BITS'(2);
    localparam logic [SEG_BITS-1:0] SEG_FIRST_BIT = SEG_BITS'(3);
    localparam logic [SEG_BITS-1:0] SEG_END_LO   = SEG_BITS'(SEG_COUNT - 2);
    localparam logic [SEG_BITS-1:0] SEG_END_HI   = SEG_BITS'(SEG_COUNT - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT    = 3'd0,
        CFG_LONG     = 3'd1,
        CFG_GAP      = 3'd2,
        CFG_END_HIGH = 3'd3,
        CFG_DEV_ADDR = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] short_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] start_gap_ticks;
        logic [TICK_W-1:0] end_high_ticks;
        logic [DEV_W-1:0]  device_address;
    } cfg_t;

    typedef struct packed {
        logic                mode;
        logic [BRIGHT_W-1:0] brightness;
    } item_t;

    typedef struct packed {
        logic                pin_level;
        logic                busy_res;
        logic                rejected;
        logic [STORED_W-1:0] stored_brightness;
    } res_t;

    typedef struct packed {
        logic              level;
        logic [TICK_W-1:0] len;
    } seg_t;

    // Level and length of segment s for the given frame bits
    function automatic seg_t seg_desc(input logic [SEG_BITS-1:0] s,
                                      input logic [FRAME_LEN-1:0] fb,
                                      input cfg_t c);
        seg_t                   d;
        logic [SEG_BITS-1:0]    off;
        logic [SEG_BITS-1:0]    k;
        logic [SEG_BITS-1:0]    pos;
        logic                   b;
        off = s - SEG_FIRST_BIT;
        k   = off >> 1;
        pos = SEG_BITS'(FRAME_LEN - 1) - k;
        b   = (k < SEG_BITS'(FRAME_LEN)) ? fb[pos[FB_IDX_BITS-1:0]] : 1'b0;
        case (s)
            SEG_START_LO: d = '{level: 1'b0, len: c.short_ticks};
            SEG_START_HI: d = '{level: 1'b1, len: c.long_ticks};
            SEG_GAP:      d = '{level: 1'b1, len: c.start_gap_ticks};
            SEG_END_LO:   d = '{level: 1'b0, len: c.short_ticks};
            SEG_END_HI:   d = '{level: 1'b1, len: c.end_high_ticks};
            default: begin
                d.level = off[0];
                if (off[0] ^ b) begin
                    d.len = c.short_ticks;
                end else begin
                    d.len = c.long_ticks;
                end
            end
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/swfls_cfg.sv
module swfls_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [swfls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swfls_pkg::TICK_W-1:0]     cfg_wdata,
    output swfls_pkg::cfg_t                  cfg
);
    import swfls_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SHORT:    cfg_next.short_ticks     = cfg_wdata;
                CFG_LONG:     cfg_next.long_ticks      = cfg_wdata;
                CFG_GAP:      cfg_next.start_gap_ticks = cfg_wdata;
                CFG_END_HIGH: cfg_next.end_high_ticks  = cfg_wdata;
                CFG_DEV_ADDR: cfg_next.device_address  = cfg_wdata[DEV_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_ticks     <= RST_SHORT;
            cfg_reg.long_ticks      <= RST_LONG;
            cfg_reg.start_gap_ticks <= RST_GAP;
            cfg_reg.end_high_ticks  <= RST_END_HIGH;
            cfg_reg.device_address  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/swfls_seq.sv
module swfls_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  swfls_pkg::item_t item,
    input  swfls_pkg::cfg_t  cfg,
    output swfls_pkg::res_t  res
);
    import swfls_pkg::*;

    logic [SEG_BITS-1:0]   seg_idx_reg,  seg_idx_next;
    logic [TIMER_BITS-1:0] tick_reg,     tick_next;
    logic [FRAME_LEN-1:0]  frame_reg,    frame_next;
    logic                  line_reg,     line_next;
    logic                  sending_reg,  sending_next;
    logic [STORED_W-1:0]   last_reg,     last_next;

    logic [STORED_W-1:0]   b;
    logic [1:0]            fm;
    logic [LEVEL_W-1:0]    fv;
    logic [FRAME_LEN-1:0]  new_frame;
    logic                  is_req;
    logic [FRAME_LEN-1:0]  fb_eff;
    logic [SEG_COUNT-1:0]  nz;
    logic [SEG_BITS-1:0]   start;
    logic                  found;
    logic [SEG_BITS-1:0]   found_idx;
    seg_t                  cur;
    logic [TIMER_BITS-1:0] tick_inc;
    logic                  seg_done;
    logic                  do_enter;
    logic                  pin;

    // Build the frame word from the masked brightness
    always_comb begin
        b = item.brightness[STORED_W-1:0];
        if (b[STORED_W-1]) begin
            fm = FM_HIGH;
            fv = (b[LEVEL_W-1:0] == '0) ? LEVEL_W'(1) : b[LEVEL_W-1:0];
        end else if (b != '0) begin
            fm = FM_LOW;
            fv = b[LEVEL_W-1:0];
        end else begin
            fm = FM_OFF;
            fv = '0;
        end
        new_frame = {ADDRESS_BITS'(cfg.device_address), fm, fv};
    end

    assign is_req = item.mode && !sending_reg;
    assign fb_eff = is_req ? new_frame : frame_reg;
    assign start  = is_req ? SEG_START_LO : seg_idx_reg + SEG_BITS'(1);

    // Nonzero-length mask, then first usable segment at or after start
    always_comb begin
        for (int i = 0; i < SEG_COUNT; i++) begin
            nz[i] = seg_desc(SEG_BITS'(i), fb_eff, cfg).len != '0;
        end
    end

    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = SEG_COUNT - 1; i >= 0; i--) begin
            if (nz[i] && (SEG_BITS'(i) >= start)) begin
                found     = 1'b1;
                found_idx = SEG_BITS'(i);
            end
        end
    end

    assign cur      = seg_desc(seg_idx_reg, frame_reg, cfg);
    assign tick_inc = tick_reg + TIMER_BITS'(1);
    assign seg_done = tick_inc >= TIMER_BITS'(cur.len);

    always_comb begin
        seg_idx_next = seg_idx_reg;
        tick_next    = tick_reg;
        frame_next   = frame_reg;
        line_next    = line_reg;
        sending_next = sending_reg;
        last_next    = last_reg;
        pin          = line_reg;
        do_enter     = 1'b0;
        if (item.mode) begin
            if (!sending_reg) begin
                frame_next   = new_frame;
                last_next    = b;
                sending_next = 1'b1;
                do_enter     = 1'b1;
            end
        end else if (sending_reg) begin
            line_next = cur.level;
            pin       = cur.level;
            tick_next = tick_inc;
            do_enter  = seg_done;
        end
        if (do_enter) begin
            tick_next = '0;
            if (found) begin
                seg_idx_next = found_idx;
            end else begin
                // nothing left to send: close the frame, idle high
                sending_next = 1'b0;
                seg_idx_next = '0;
                line_next    = 1'b1;
            end
        end
    end

    always_comb begin
        res.pin_level         = pin;
        res.busy_res          = sending_next;
        res.rejected          = item.mode && sending_reg;
        res.stored_brightness = last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_idx_reg <= '0;
            tick_reg    <= '0;
            frame_reg   <= '0;
            line_reg    <= 1'b0;
            sending_reg <= 1'b0;
            last_reg    <= '0;
        end else if (step) begin
            seg_idx_reg <= seg_idx_next;
            tick_reg    <= tick_next;
            frame_reg   <= frame_next;
            line_reg    <= line_next;
            sending_reg <= sending_next;
            last_reg    <= last_next;
        end
    end

    a_idle_seg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !sending_reg |-> seg_idx_reg == '0)
        else $error("segment index not parked while idle");

    a_seg_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_idx_reg < SEG_BITS'(SEG_COUNT))
        else $error("segment index past end of frame");

    a_req_stores: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.mode && !sending_reg
            |=> last_reg == $past(item.brightness[STORED_W-1:0]))
        else $error("accepted request did not store its brightness");

endmodule

>>> hw/rtl/single_wire_flash_level_sender_unit.sv
// Single-wire flash level sender. Each input beat is either a time tick
// (s_mode = 0) or a brightness request (s_mode = 1); every beat yields exactly
// one result beat with the wire level for that beat, the busy flag after it,
// a reject flag for requests that arrive mid-frame, and the last accepted
// 7-bit brightness. A request while idle loads a frame of start bit, gap,
// address and data bits (MSB first, pulse-width coded) and end mark; each
// following tick moves the wire one tick through it. One beat is accepted per
// clock while the result side is not stalled by m_ready; a result passes through
// the input register, then the result register, and the whole frame step is done
// combinationally between them. Timing registers are written through cfg_we/
// cfg_index/cfg_wdata and must only be changed while no beat is held inside the
// block.
module single_wire_flash_level_sender_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_mode,
    input  logic [swfls_pkg::BRIGHT_W-1:0]       s_brightness,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_pin_level,
    output logic                                 m_busy_res,
    output logic                                 m_rejected,
    output logic [swfls_pkg::STORED_W-1:0]       m_stored_brightness,
    input  logic                                 cfg_we,
    input  logic [swfls_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swfls_pkg::TICK_W-1:0]         cfg_wdata
);
    import swfls_pkg::*;

    logic  in_valid_reg, in_valid_next;
    item_t in_item_reg;
    logic  out_valid_reg, out_valid_next;
    res_t  out_res_reg;
    logic  advance;
    cfg_t  cfg;
    res_t  res;

    // advance the held beat whenever the result slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{mode: s_mode, brightness: s_brightness};
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    swfls_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    swfls_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign m_valid             = out_valid_reg;
    assign m_pin_level         = out_res_reg.pin_level;
    assign m_busy_res          = out_res_reg.busy_res;
    assign m_rejected          = out_res_reg.rejected;
    assign m_stored_brightness = out_res_reg.stored_brightness;

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("stepped beat did not reach the result register");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("held input beat lost or changed");

    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.rejected |-> res.busy_res)
        else $error("request rejected while no frame in progress");

endmodule

>>> test/wire_frame_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the flash level sender, predicts every result beat
// from the accepted input beats and the register writes, and compares.
module wire_frame_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_mode,
    input  logic [swfls_pkg::BRIGHT_W-1:0]  s_brightness,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_pin_level,
    input  logic                            m_busy_res,
    input  logic                            m_rejected,
    input  logic [swfls_pkg::STORED_W-1:0]  m_stored_brightness,
    input  logic                            cfg_we,
    input  logic [swfls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swfls_pkg::TICK_W-1:0]    cfg_wdata,
    input  logic                            wrap_up,
    output logic                            frame_on,
    output int                              due_count,
    output int                              fail_count,
    output int                              beats_checked,
    output int                              frames_sent,
    output int                              drops_seen
);
    import swfls_pkg::*;

    typedef struct packed {
        logic              lvl;
        logic [TICK_W-1:0] dur;
    } phase_t;

    logic [TICK_W-1:0]     short_r;
    logic [TICK_W-1:0]     long_r;
    logic [TICK_W-1:0]     gap_r;
    logic [TICK_W-1:0]     endhi_r;
    logic [DEV_W-1:0]      addr_r;

    logic [SEG_BITS-1:0]   seg_q;
    logic [TIMER_BITS-1:0] ticks_q;
    logic [FRAME_LEN-1:0]  frame_q;
    logic                  line_q;
    logic                  sending_q;
    logic [STORED_W-1:0]   kept_q;

    res_t                  due_beats[$];
    bit                    wrapped = 1'b0;

    task automatic report(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= 40) begin
            $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
        end
    endtask

    // Level and duration of one segment of the frame now loaded
    function automatic phase_t phase_of(input logic [SEG_BITS-1:0] s);
        phase_t p;
        int     rel;
        int     k;
        logic   b;
        case (s)
            SEG_START_LO: p = '{lvl: 1'b0, dur: short_r};
            SEG_START_HI: p = '{lvl: 1'b1, dur: long_r};
            SEG_GAP:      p = '{lvl: 1'b1, dur: gap_r};
            SEG_END_LO:   p = '{lvl: 1'b0, dur: short_r};
            SEG_END_HI:   p = '{lvl: 1'b1, dur: endhi_r};
            default: begin
                rel   = int'(s) - int'(SEG_FIRST_BIT);
                k     = rel / 2;
                b     = frame_q[FRAME_LEN-1-k];
                p.lvl = 1'(rel % 2);
                // a one is short low then long high, a zero the reverse
                p.dur = (p.lvl == b) ? long_r : short_r;
            end
        endcase
        return p;
    endfunction

    // Land on the first non-empty segment at or after 'from'; past the end, close the frame
    task automatic skip_empty(input int from);
        int     s;
        phase_t p;
        s = from;
        while (s < SEG_COUNT) begin
            p = phase_of(SEG_BITS'(s));
            if (p.dur != '0) break;
            s++;
        end
        ticks_q = '0;
        if (s >= SEG_COUNT) begin
            sending_q = 1'b0;
            seg_q     = '0;
            line_q    = 1'b1;
            frames_sent++;
        end else begin
            seg_q = SEG_BITS'(s);
        end
    endtask

    task automatic step_wire(input logic is_req, input logic [BRIGHT_W-1:0] br);
        res_t                r;
        logic [STORED_W-1:0] b;
        logic [LEVEL_W-1:0]  lvl6;
        logic [7:0]          word;
        phase_t              p;
        r.pin_level = line_q;
        r.rejected  = 1'b0;
        if (is_req) begin
            if (sending_q) begin
                r.rejected = 1'b1;
                drops_seen++;
            end else begin
                b = br[STORED_W-1:0];
                if (b[6]) begin
                    lvl6 = (b[5:0] == 6'd0) ? 6'd1 : b[5:0];
                    word = {FM_HIGH, lvl6};
                end else if (b != '0) begin
                    word = {FM_LOW, b[5:0]};
                end else begin
                    word = {FM_OFF, 6'd0};
                end
                frame_q   = FRAME_LEN'({addr_r, word});
                kept_q    = b;
                sending_q = 1'b1;
                skip_empty(0);
            end
        end else if (sending_q) begin
            p           = phase_of(seg_q);
            line_q      = p.lvl;
            r.pin_level = p.lvl;
            ticks_q     = ticks_q + 1'b1;
            if (ticks_q >= TIMER_BITS'(p.dur)) skip_empty(int'(seg_q) + 1);
        end
        r.busy_res          = sending_q;
        r.stored_brightness = kept_q;
        due_beats.push_back(r);
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            short_r   = RST_SHORT;
            long_r    = RST_LONG;
            gap_r     = RST_GAP;
            endhi_r   = RST_END_HIGH;
            addr_r    = '0;
            seg_q     = '0;
            ticks_q   = '0;
            frame_q   = '0;
            line_q    = 1'b0;
            sending_q = 1'b0;
            kept_q    = '0;
            due_beats.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SHORT:    short_r = cfg_wdata;
                    CFG_LONG:     long_r  = cfg_wdata;
                    CFG_GAP:      gap_r   = cfg_wdata;
                    CFG_END_HIGH: endhi_r = cfg_wdata;
                    CFG_DEV_ADDR: addr_r  = cfg_wdata[DEV_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) step_wire(s_mode, s_brightness);
            if (m_valid && m_ready) begin
                if (due_beats.size() == 0) begin
                    report("result beat with nothing due", 1, 0);
                end else begin
                    want = due_beats.pop_front();
                    beats_checked++;
                    if (m_pin_level !== want.pin_level)
                        report("pin_level", m_pin_level, want.pin_level);
                    if (m_busy_res !== want.busy_res)
                        report("busy_res", m_busy_res, want.busy_res);
                    if (m_rejected !== want.rejected)
                        report("rejected", m_rejected, want.rejected);
                    if (m_stored_brightness !== want.stored_brightness)
                        report("stored_brightness", m_stored_brightness,
                               want.stored_brightness);
                end
            end
            if (wrap_up && !wrapped) begin
                wrapped = 1'b1;
                if (due_beats.size() != 0)
                    report("result beats never delivered", due_beats.size(), 0);
            end
        end
        frame_on  <= sending_q;
        due_count <= due_beats.size();
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import swfls_pkg::*;

    localparam logic BEAT_TICK = 1'b0;
    localparam logic BEAT_REQ  = 1'b1;
    // index past the register map; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int LONG_HOLD    = 240;
    localparam int RANDOM_BEATS = 700;
    localparam int RESET_TICKS  = 150;
    localparam int WIDE_TICKS   = 40;
    localparam logic [8:0][7:0] EDGE_LEVELS =
        {8'h00, 8'h80, 8'h40, 8'h41, 8'h7f, 8'h01, 8'h3f, 8'hc0, 8'hbf};

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_mode       = 1'b0;
    logic [BRIGHT_W-1:0]  s_brightness = '0;
    logic                 m_ready      = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [TICK_W-1:0]    cfg_wdata    = '0;
    logic                 wrap_up      = 1'b0;

    logic                 s_ready;
    logic                 m_valid;
    logic                 m_pin_level;
    logic                 m_busy_res;
    logic                 m_rejected;
    logic [STORED_W-1:0]  m_stored_brightness;

    logic                 frame_on;
    int                   due_count;
    int                   fail_count;
    int                   beats_checked;
    int                   frames_sent;
    int                   drops_seen;

    bit                   calm       = 1'b0;
    int                   hold_asked = 0;
    int                   hold_given = 0;
    int                   beats_sent = 0;
    int                   settings   = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    single_wire_flash_level_sender_unit u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_brightness        (s_brightness),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_pin_level         (m_pin_level),
        .m_busy_res          (m_busy_res),
        .m_rejected          (m_rejected),
        .m_stored_brightness (m_stored_brightness),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata)
    );

    wire_frame_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_brightness        (s_brightness),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_pin_level         (m_pin_level),
        .m_busy_res          (m_busy_res),
        .m_rejected          (m_rejected),
        .m_stored_brightness (m_stored_brightness),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .wrap_up             (wrap_up),
        .frame_on            (frame_on),
        .due_count           (due_count),
        .fail_count          (fail_count),
        .beats_checked       (beats_checked),
        .frames_sent         (frames_sent),
        .drops_seen          (drops_seen)
    );

    task automatic send_beat(input logic mode, input logic [BRIGHT_W-1:0] br);
        int gap;
        gap = calm ? 0 : int'($urandom_range(11, 0));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_brightness <= br;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    // Tick until the frame is over; frame_on lags one beat, so one idle tick may follow
    task automatic tick_out(input bit noisy);
        do begin
            if (noisy && $urandom_range(9, 0) == 0)
                send_beat(BEAT_REQ, BRIGHT_W'($urandom_range(255, 0)));
            send_beat(BEAT_TICK, BRIGHT_W'($urandom_range(255, 0)));
        end while (frame_on);
    endtask

    task automatic play_frame(input logic [BRIGHT_W-1:0] br, input bit noisy);
        send_beat(BEAT_REQ, br);
        tick_out(noisy);
    endtask

    // Drop valid and wait until every predicted beat has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic set_timing(input logic [TICK_W-1:0] sh, input logic [TICK_W-1:0] lg,
                              input logic [TICK_W-1:0] gp, input logic [TICK_W-1:0] eh,
                              input logic [TICK_W-1:0] ad);
        put_reg(CFG_SHORT, sh);
        put_reg(CFG_LONG, lg);
        put_reg(CFG_GAP, gp);
        put_reg(CFG_END_HIGH, eh);
        put_reg(CFG_DEV_ADDR, ad);
        put_reg(CFG_SPARE, TICK_W'($urandom_range(4095, 0)));
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [TICK_W-1:0] pick_len(input int lo);
        if ($urandom_range(7, 0) == 0) return '0;
        return TICK_W'($urandom_range(6, lo));
    endfunction

    // Random brightness, often with the low six bits cleared to hit the mode edges
    function automatic logic [BRIGHT_W-1:0] pick_level();
        logic [BRIGHT_W-1:0] r;
        r = BRIGHT_W'($urandom_range(255, 0));
        if ($urandom_range(3, 0) == 0) r[5:0] = '0;
        return r;
    endfunction

    // Result side: wait a drawn number of cycles before taking each beat
    initial begin
        int wait_n;
        forever begin
            if (hold_asked != hold_given) begin
                hold_given = hold_asked;
                wait_n     = LONG_HOLD;
            end else begin
                wait_n = calm ? 0 : int'($urandom_range(11, 0));
            end
            if (wait_n > 0) begin
                m_ready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        #(20_000_000);
        $display("FAIL single_wire_flash_level_sender_unit");
        $finish;
    end

    initial begin
        int first;
        int round;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset timing: line low before the first frame, then a refused request mid-frame;
        // walk the start bit and gap at reset lengths, then shorten the rest of the frame
        repeat (3) send_beat(BEAT_TICK, 8'hff);
        send_beat(BEAT_REQ, 8'hff);
        send_beat(BEAT_TICK, 8'h00);
        send_beat(BEAT_REQ, 8'h2a);
        repeat (RESET_TICKS) send_beat(BEAT_TICK, BRIGHT_W'($urandom_range(255, 0)));
        drain();
        set_timing(12'd1, 12'd1, 12'd0, 12'd1, 12'h000);
        tick_out(1'b0);
        drain();

        set_timing(12'd1, 12'd2, 12'd0, 12'd1, 12'hffd);
        for (int i = 0; i < 9; i++) play_frame(EDGE_LEVELS[i], 1'b0);
        drain();

        // empty segments: everything zero, then only some phases zero
        set_timing(12'd0, 12'd0, 12'd0, 12'd0, 12'h000);
        play_frame(8'h23, 1'b0);
        send_beat(BEAT_REQ, 8'h81);
        drain();
        set_timing(12'd0, 12'd3, 12'd0, 12'd2, 12'h003);
        play_frame(8'h55, 1'b0);
        drain();
        set_timing(12'd2, 12'd0, 12'd1, 12'd0, 12'h006);
        play_frame(8'h6a, 1'b0);
        drain();
        set_timing(12'd1, 12'd1, 12'd0, 12'd1, 12'h007);
        play_frame(8'hc1, 1'b1);
        drain();

        // full-scale timing: hold the first phase a while, then shorten to finish
        set_timing(12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
        send_beat(BEAT_REQ, 8'h7f);
        repeat (WIDE_TICKS) send_beat(BEAT_TICK, BRIGHT_W'($urandom_range(255, 0)));
        drain();
        set_timing(12'd1, 12'd1, 12'd1, 12'd1, 12'h007);
        tick_out(1'b0);
        drain();

        first = beats_sent;
        round = 0;
        while (beats_sent - first < RANDOM_BEATS) begin
            set_timing(pick_len(1), pick_len(1), pick_len(0), pick_len(1),
                       TICK_W'($urandom_range(4095, 0)));
            calm = (round != 1) && ($urandom_range(3, 0) == 0);
            if (round == 1) hold_asked++;
            repeat ($urandom_range(3, 1)) begin
                repeat ($urandom_range(2, 0))
                    send_beat(BEAT_TICK, BRIGHT_W'($urandom_range(255, 0)));
                play_frame(pick_level(), 1'b1);
            end
            drain();
            round++;
        end
        calm = 1'b0;

        drain();
        repeat (8) @(posedge aclk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge aclk);
        $display("Checked %0d result beats over %0d register settings: %0d frames, %0d busy drops.",
                 beats_checked, settings, frames_sent, drops_seen);
        $display("Run included empty segments, 4095-tick registers, mid-frame retiming and a %0d-cycle output stall.",
                 LONG_HOLD);
        if (fail_count == 0) begin
            $display("PASS single_wire_flash_level_sender_unit");
        end else begin
            $display("FAIL single_wire_flash_level_sender_unit");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/swfls_pkg.sv
hw/rtl/swfls_cfg.sv
hw/rtl/swfls_seq.sv
hw/rtl/single_wire_flash_level_sender_unit.sv
test/wire_frame_checker.sv
test/tb_top.sv
